// ===== rtl/core/mwlfo_pkg.sv =====
// Package for the multi-waveform LFO: field widths, codes, the queue entry type
// and the constant function that builds the quarter-wave sine table.
// No dependencies; every module of the block imports it.
package mwlfo_pkg;

  // Widths of the configuration registers and the item fields.
  localparam int KNOB_W      = 17;
  localparam int FSI_W       = 23;
  localparam int OFFSET_W    = 24;
  localparam int SEL_W       = 2;
  localparam int COUNT_W     = 13;
  localparam int MOD_W       = 18;
  localparam int VALUE_W     = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  // Per-sample increment is knob * full scale in Q16, so 16 fraction bits drop.
  localparam int INC_PROD_W  = KNOB_W + FSI_W;
  localparam int INC_W       = INC_PROD_W - 16;
  localparam int STEP_PROD_W = INC_W + COUNT_W;

  // Longest block that one advance item may ask for.
  localparam logic [COUNT_W-1:0] MAX_BLOCK = 13'd4096;

  // Knob of 1.0 in Q16.
  localparam logic [KNOB_W-1:0] KNOB_ONE = 17'd65536;

  // Reset values of the configuration registers.
  localparam logic [KNOB_W-1:0]   BASE_KNOB_RST     = 17'd16384;
  localparam logic [FSI_W-1:0]    FSI_RST           = 23'd6990;
  localparam logic [OFFSET_W-1:0] RESTART_PHASE_RST = 24'd0;

  // Item opcodes.
  typedef enum logic [0:0] {
    OP_ADVANCE = 1'b0,
    OP_RESTART = 1'b1
  } mwlfo_op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BASE_KNOB     = 2'd0,
    REG_FULL_SCALE    = 2'd1,
    REG_RESTART_PHASE = 2'd2,
    REG_WAVE_SELECT   = 2'd3
  } mwlfo_reg_t;

  // Waveform codes.
  typedef enum logic [SEL_W-1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SAW      = 2'd1,
    WAVE_SQUARE   = 2'd2,
    WAVE_TRIANGLE = 2'd3
  } mwlfo_wave_t;

  // Sequencer states of the phase engine.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INC,
    ST_STEP,
    ST_PHASE,
    ST_ISSUE
  } mwlfo_state_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic               restart;
    logic [KNOB_W-1:0]  knob;
    logic [COUNT_W-1:0] count;
  } mwlfo_entry_t;

  localparam int QUEUE_DEPTH = 2;

  // Q30 odd Taylor coefficients of sin(pi/2 * x).
  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] SINE_C0 = 64'd1686629713;
  localparam logic [63:0] SINE_C1 = 64'd693598670;
  localparam logic [63:0] SINE_C2 = 64'd85569306;
  localparam logic [63:0] SINE_C3 = 64'd5026995;
  localparam logic [63:0] SINE_C4 = 64'd172272;

  // Table entry for a Q30 position x in 0..1, rounded to Q15 and capped.
  // Only ever called with elaboration-time constants.
  function automatic logic [14:0] sine_entry(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] y;
    logic [63:0] q;
    x2 = (x * x) >> 30;
    t  = SINE_C3 - ((x2 * SINE_C4) >> 30);
    t  = SINE_C2 - ((x2 * t) >> 30);
    t  = SINE_C1 - ((x2 * t) >> 30);
    t  = SINE_C0 - ((x2 * t) >> 30);
    y  = (x * t) >> 30;
    q  = (y + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[14:0];
  endfunction

endpackage

// ===== rtl/core/mwlfo_front.sv =====
// Front end of the LFO: accepts items, works out the clamped knob and block
// length, and hands a classified entry to the queue. Uses mwlfo_pkg.
module mwlfo_front import mwlfo_pkg::*; (
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                opcode,
  input  logic [COUNT_W-1:0]  sample_count,
  input  logic signed [MOD_W-1:0] modulation,
  input  logic [KNOB_W-1:0]   base_knob,
  input  logic                queue_full,
  output logic                push,
  output mwlfo_entry_t        push_entry
);

  logic signed [KNOB_W+1:0] knob_sum;
  logic [KNOB_W-1:0]        knob_clamped;
  logic [COUNT_W-1:0]       count_clamped;

  // The queue is the only thing that can hold the input back.
  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;

  // Knob plus modulation, held to 0..1 in Q16.
  always_comb begin
    knob_sum = $signed({2'b00, base_knob}) + (KNOB_W+2)'(modulation);
    if (knob_sum < 0) begin
      knob_clamped = '0;
    end else if (knob_sum > $signed({2'b00, KNOB_ONE})) begin
      knob_clamped = KNOB_ONE;
    end else begin
      knob_clamped = knob_sum[KNOB_W-1:0];
    end
  end

  // Over-long blocks advance by the longest allowed block.
  assign count_clamped = (sample_count > MAX_BLOCK) ? MAX_BLOCK : sample_count;

  always_comb begin
    push_entry.restart = (opcode == OP_RESTART);
    push_entry.knob    = knob_clamped;
    push_entry.count   = count_clamped;
  end

endmodule

// ===== rtl/core/mwlfo_queue.sv =====
// Short queue between the LFO front end and the phase engine.
// Holds classified entries of type mwlfo_entry_t from mwlfo_pkg.
module mwlfo_queue import mwlfo_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  mwlfo_entry_t push_entry,
  input  logic         pop,
  output mwlfo_entry_t head,
  output logic         empty,
  output logic         full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  mwlfo_entry_t     entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign empty = (fill == '0);
  assign full  = (fill == CNT_W'(QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  // Storage is written only on push; no reset needed.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // The engine must never take an entry from an empty queue.
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue popped while empty");

endmodule

// ===== rtl/core/mwlfo_back.sv =====
// Phase engine of the LFO: works out the increment, the block step and the
// new phase for each queued entry, then hands the phase to the shaper.
// Uses mwlfo_pkg.
module mwlfo_back import mwlfo_pkg::*; #(
  parameter int PHASE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mwlfo_entry_t          head,
  input  logic                  empty,
  output logic                  pop,
  input  logic [FSI_W-1:0]      full_scale_increment,
  input  logic [OFFSET_W-1:0]   restart_phase,
  input  logic                  shaper_ready,
  output logic                  start,
  output logic [PHASE_BITS-1:0] phase
);

  mwlfo_state_t state;
  mwlfo_state_t state_next;

  logic                  restart_r;
  logic [KNOB_W-1:0]     knob_r;
  logic [COUNT_W-1:0]    count_r;
  logic [INC_W-1:0]      inc_r;
  logic [PHASE_BITS-1:0] step_r;
  logic [INC_PROD_W-1:0] inc_prod;
  logic [STEP_PROD_W-1:0] step_prod;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, queue pop and hand-over to the shaper.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    start      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = ST_INC;
        end
      end
      ST_INC:   state_next = ST_STEP;
      ST_STEP:  state_next = ST_PHASE;
      ST_PHASE: state_next = ST_ISSUE;
      ST_ISSUE: begin
        if (shaper_ready) begin
          start      = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // One multiplier per step, each product registered.
  assign inc_prod  = INC_PROD_W'(knob_r) * INC_PROD_W'(full_scale_increment);
  assign step_prod = STEP_PROD_W'(inc_r) * STEP_PROD_W'(count_r);

  always_ff @(posedge clk) begin
    if (pop) begin
      restart_r <= head.restart;
      knob_r    <= head.knob;
      count_r   <= head.count;
    end
    if (state == ST_INC) begin
      inc_r <= inc_prod[INC_PROD_W-1:16];
    end
    if (state == ST_STEP) begin
      step_r <= PHASE_BITS'(step_prod);
    end
  end

  // The phase accumulator wraps modulo one waveform period; a restart entry loads the restart phase instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (state == ST_PHASE) begin
      phase <= restart_r ? PHASE_BITS'(restart_phase) : phase + step_r;
    end
  end

  a_start_ready: assert property (@(posedge clk) disable iff (rst) start |-> shaper_ready)
    else $error("phase handed over while shaper busy");
  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
      (state != ST_PHASE) |=> $stable(phase))
    else $error("phase changed outside the update step");

endmodule

// ===== rtl/core/mwlfo_shaper.sv =====
// Waveform shaper of the LFO: turns a phase into a Q15 sine, sawtooth,
// square or triangle value and holds it in the output register.
// Uses mwlfo_pkg for codes and the sine table function.
module mwlfo_shaper import mwlfo_pkg::*; #(
  parameter int PHASE_BITS       = 24,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [PHASE_BITS-1:0]     phase,
  input  logic [SEL_W-1:0]          waveform_select,
  output logic                      ready,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic signed [VALUE_W-1:0] lfo_value
);

  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int QPOS_W = PHASE_BITS - 2;
  localparam int PROD_W = PHASE_BITS - 1 + IDX_W;
  localparam logic [PHASE_BITS-2:0] QUARTER = {1'b1, {QPOS_W{1'b0}}};

  // Quarter-wave table, built at elaboration.
  logic [14:0] rom [SINE_TABLE_DEPTH + 1];

  for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_rom
    localparam logic [63:0] XPOS = (64'(i) * Q30_ONE) / 64'(SINE_TABLE_DEPTH);
    assign rom[i] = sine_entry(XPOS);
  end

  logic                  va;
  logic                  vb;
  logic                  vc;
  logic [PHASE_BITS-1:0] ph_a;

  logic [1:0]            quad;
  logic [PHASE_BITS-2:0] pos_ext;
  logic [PROD_W-1:0]     idx_prod;
  logic [15:0]           p16;
  logic signed [17:0]    saw_raw;
  logic signed [18:0]    tri_raw;
  logic signed [VALUE_W-1:0] shape_val;
  logic                  above_half;

  logic [IDX_W-1:0]      idx_b;
  logic                  neg_b;
  logic                  sine_b;
  logic signed [VALUE_W-1:0] shape_b;

  logic [14:0]           rom_c;
  logic                  neg_c;
  logic                  sine_c;
  logic signed [VALUE_W-1:0] shape_c;
  logic signed [VALUE_W-1:0] sine_val;

  // One item at a time: free once nothing is in flight or waiting.
  assign ready = !(va || vb || vc || result_valid);

  // Sine table index: position in the quarter, mirrored in falling quarters.
  assign quad     = ph_a[PHASE_BITS-1 -: 2];
  assign pos_ext  = quad[0] ? QUARTER - {1'b0, ph_a[QPOS_W-1:0]} : {1'b0, ph_a[QPOS_W-1:0]};
  assign idx_prod = PROD_W'(pos_ext) * PROD_W'(SINE_TABLE_DEPTH);

  // The sawtooth and triangle come from the top sixteen phase bits; the square also uses the lower bits.
  assign p16        = ph_a[PHASE_BITS-1 -: 16];
  assign above_half = ph_a[PHASE_BITS-1] && (|ph_a[PHASE_BITS-2:0]);
  assign saw_raw    = 18'sd32768 - $signed({2'b00, p16});
  assign tri_raw    = ph_a[PHASE_BITS-1] ? 19'sd98304 - $signed({2'b00, p16, 1'b0})
                                         : $signed({2'b00, p16, 1'b0}) - 19'sd32768;

  always_comb begin
    case (waveform_select)
      WAVE_SAW: begin
        shape_val = (saw_raw > 18'sd32767) ? 16'sd32767 : VALUE_W'(saw_raw);
      end
      WAVE_SQUARE: begin
        shape_val = above_half ? -16'sd32767 : 16'sd32767;
      end
      WAVE_TRIANGLE: begin
        if (tri_raw > 19'sd32767) begin
          shape_val = 16'sd32767;
        end else if (tri_raw < -19'sd32767) begin
          shape_val = -16'sd32767;
        end else begin
          shape_val = VALUE_W'(tri_raw);
        end
      end
      default: shape_val = '0;
    endcase
  end

  // Stage valids and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      va           <= 1'b0;
      vb           <= 1'b0;
      vc           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      va <= start;
      vb <= va;
      vc <= vb;
      if (vc) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign sine_val = neg_c ? -$signed({1'b0, rom_c}) : $signed({1'b0, rom_c});

  // Payload stages: phase, table index and shape, table read, final value.
  always_ff @(posedge clk) begin
    if (start) begin
      ph_a <= phase;
    end
    if (va) begin
      idx_b   <= idx_prod[QPOS_W +: IDX_W];
      neg_b   <= quad[1];
      sine_b  <= (waveform_select == WAVE_SINE);
      shape_b <= shape_val;
    end
    if (vb) begin
      rom_c   <= rom[idx_b];
      neg_c   <= neg_b;
      sine_c  <= sine_b;
      shape_c <= shape_b;
    end
    if (vc) begin
      lfo_value <= sine_c ? sine_val : shape_c;
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
      $onehot0({va, vb, vc, result_valid}))
    else $error("more than one item inside the shaper");
  a_result_follows: assert property (@(posedge clk) disable iff (rst) vc |=> result_valid)
    else $error("finished value did not reach the output register");

endmodule

// ===== rtl/core/multi_waveform_lfo.sv =====
// Multi-waveform LFO: the phase engine's five-step sequence (two registered
// multiplies) takes one entry at a time, and the shaper takes a new phase only
// once its last value has left the output register. Reset clears the phase
// and loads the configuration reset values; no table or queue clearing pass
// is needed. Uses mwlfo_pkg and the mwlfo_* modules.
module multi_waveform_lfo import mwlfo_pkg::*; #(
  parameter int PHASE_BITS       = 24,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic                      opcode,
  input  logic [COUNT_W-1:0]        sample_count,
  input  logic signed [MOD_W-1:0]   modulation,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic signed [VALUE_W-1:0] lfo_value,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  logic [KNOB_W-1:0]   base_knob;
  logic [FSI_W-1:0]    full_scale_increment;
  logic [OFFSET_W-1:0] restart_phase;
  logic [SEL_W-1:0]    waveform_select;

  mwlfo_entry_t          push_entry;
  mwlfo_entry_t          head;
  logic                  push;
  logic                  pop;
  logic                  empty;
  logic                  full;
  logic                  shaper_ready;
  logic                  start;
  logic [PHASE_BITS-1:0] phase;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_knob            <= BASE_KNOB_RST;
      full_scale_increment <= FSI_RST;
      restart_phase        <= RESTART_PHASE_RST;
      waveform_select      <= WAVE_SINE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE_KNOB:     base_knob            <= cfg_data[KNOB_W-1:0];
        REG_FULL_SCALE:    full_scale_increment <= cfg_data[FSI_W-1:0];
        REG_RESTART_PHASE: restart_phase        <= cfg_data[OFFSET_W-1:0];
        REG_WAVE_SELECT:   waveform_select      <= cfg_data[SEL_W-1:0];
        default: ;
      endcase
    end
  end

  mwlfo_front u_front (
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .opcode       (opcode),
    .sample_count (sample_count),
    .modulation   (modulation),
    .base_knob    (base_knob),
    .queue_full   (full),
    .push         (push),
    .push_entry   (push_entry)
  );

  mwlfo_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  mwlfo_back #(
    .PHASE_BITS (PHASE_BITS)
  ) u_back (
    .clk                  (clk),
    .rst                  (rst),
    .head                 (head),
    .empty                (empty),
    .pop                  (pop),
    .full_scale_increment (full_scale_increment),
    .restart_phase        (restart_phase),
    .shaper_ready         (shaper_ready),
    .start                (start),
    .phase                (phase)
  );

  mwlfo_shaper #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_shaper (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .phase           (phase),
    .waveform_select (waveform_select),
    .ready           (shaper_ready),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .lfo_value       (lfo_value)
  );

endmodule
